[hw/rtl/prn_pkg.sv]
// Shared types, constants and arithmetic helpers for the palette remap matcher.
// Used by every module and interface of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package prn_pkg;

    // Palette geometry
    localparam int PALETTE_DEPTH = 256;
    localparam int IDX_W         = $clog2(PALETTE_DEPTH);
    localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);

    // Field widths
    localparam int CH_W    = 8;
    localparam int SQ_W    = 16;
    localparam int DIST_W  = 18;
    localparam int LSUM_W  = 16;
    localparam int PROD_W  = 18;
    localparam int LUMA_W  = 12;
    localparam int GPROD_W = 19;
    localparam int QUO_W   = 13;
    localparam int CMP_W   = 10;

    // APB register port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Luma weights and channel ceiling
    localparam logic [CH_W-1:0] LUMA_R = 8'd77;
    localparam logic [CH_W-1:0] LUMA_G = 8'd151;
    localparam logic [CH_W-1:0] LUMA_B = 8'd28;
    localparam logic [CH_W-1:0] CH_MAX = 8'd255;

    // Division by one hundred as a reciprocal multiply, exact for any 19-bit dividend
    localparam int              DIV100_MUL_W = 20;
    localparam int              DIV100_SHIFT = 26;
    localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = 20'd671089;

    // Item kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [1:0] {
        MODE_PASS,
        MODE_BRIGHT,
        MODE_GRAY,
        MODE_GRAY_BRIGHT
    } t_mode;

    typedef enum logic [2:0] {
        REG_MODE,
        REG_PERCENT,
        REG_GRAY,
        REG_BLOCKED_START,
        REG_BLOCKED_COUNT,
        REG_START_COLOR
    } t_reg_idx;

    typedef struct packed {
        t_mode        mode;
        logic [9:0]   percent;
        logic [6:0]   gray;
        logic [7:0]   blocked_start;
        logic [8:0]   blocked_count;
        logic [8:0]   start_color;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        mode:          MODE_PASS,
        percent:       10'd100,
        gray:          7'd0,
        blocked_start: 8'd0,
        blocked_count: 9'd0,
        start_color:   9'd236
    };

    // One palette entry as held by a ring cell
    typedef struct packed {
        logic            cycling;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_entry;

    // Entry leaving the head of the ring toward the distance unit
    typedef struct packed {
        logic             valid;
        logic             cand;
        logic [IDX_W-1:0] idx;
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
    } t_probe;

    // Running best match
    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  idx;
        logic [DIST_W-1:0] sq_dist;
    } t_best;

    // Floor of x / 100 by multiplying with a scaled reciprocal.
    function automatic logic [QUO_W-1:0] div100(input logic [GPROD_W-1:0] x);
        logic [GPROD_W+DIV100_MUL_W-1:0] p;
        p = (GPROD_W + DIV100_MUL_W)'(x) * (GPROD_W + DIV100_MUL_W)'(DIV100_MUL);
        return p[DIV100_SHIFT +: QUO_W];
    endfunction

    // Saturate a quotient at the channel ceiling.
    function automatic logic [CH_W-1:0] sat_byte(input logic [QUO_W-1:0] q);
        return (q > QUO_W'(CH_MAX)) ? CH_MAX : q[CH_W-1:0];
    endfunction

endpackage

`default_nettype wire

[hw/rtl/prn_in_if.sv]
// Input channel of the palette remap matcher: palette writes and color queries.
// Depends on prn_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface prn_in_if;
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [7:0]                entry_index;
    logic [prn_pkg::CH_W-1:0]  red;
    logic [prn_pkg::CH_W-1:0]  green;
    logic [prn_pkg::CH_W-1:0]  blue;
    logic                      entry_cycling;

    modport source (
        output valid, kind, entry_index, red, green, blue, entry_cycling,
        input  ready
    );
    modport sink (
        input  valid, kind, entry_index, red, green, blue, entry_cycling,
        output ready
    );
endinterface

`default_nettype wire

[hw/rtl/prn_out_if.sv]
// Result channel of the palette remap matcher: one beat per query.
// Depends on prn_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface prn_out_if;
    logic                        valid;
    logic                        ready;
    logic                        found;
    logic [7:0]                  best_index;
    logic [prn_pkg::DIST_W-1:0]  best_distance;
    logic [prn_pkg::CH_W-1:0]    ideal_red;
    logic [prn_pkg::CH_W-1:0]    ideal_green;
    logic [prn_pkg::CH_W-1:0]    ideal_blue;

    modport source (
        output valid, found, best_index, best_distance, ideal_red, ideal_green, ideal_blue,
        input  ready
    );
    modport sink (
        input  valid, found, best_index, best_distance, ideal_red, ideal_green, ideal_blue,
        output ready
    );
endinterface

`default_nettype wire

[hw/rtl/palette_remap_nearest_color.sv]
// Top level of the palette remap matcher: APB registers, palette ring, control.
// Depends on prn_pkg, prn_in_if, prn_out_if, prn_cell, prn_xform and prn_dist.
//
// A write beat loads one palette entry into its ring cell and gives no result. A query
// beat first forms the ideal color in the color pipeline; then the ring of cells rotates
// once past the single distance unit at its head; then the sequencer waits for that
// unit's pipeline to drain and loads the result register, waiting first while that
// register still holds a result that has not been taken. The next beat can be taken in
// the cycle after the result loads. The full rotation always runs, so every query scans
// the whole ring regardless of start color. Input is taken only between queries; a
// finished result waits in the output register without holding up the next beat.
`timescale 1ns / 1ps
`default_nettype none

module palette_remap_nearest_color (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [prn_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [prn_pkg::DATA_W-1:0]     pwdata,
    output logic      [prn_pkg::DATA_W-1:0]     prdata,
    output logic                                pready,
    prn_in_if.sink                              i_in,
    prn_out_if.source                           o_out
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_XFORM,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    localparam logic [prn_pkg::CNT_W-1:0] CNT_LAST = prn_pkg::CNT_W'(prn_pkg::PALETTE_DEPTH - 1);

    t_state                          r_state;
    logic [prn_pkg::CNT_W-1:0]       r_cnt;
    prn_pkg::t_cfg                   r_cfg;
    logic                            r_out_valid;
    logic                            r_out_found;
    logic [7:0]                      r_out_idx;
    logic [prn_pkg::DIST_W-1:0]      r_out_dist;
    logic [prn_pkg::CH_W-1:0]        r_out_red;
    logic [prn_pkg::CH_W-1:0]        r_out_green;
    logic [prn_pkg::CH_W-1:0]        r_out_blue;

    prn_pkg::t_entry                 w_cell [prn_pkg::PALETTE_DEPTH];
    prn_pkg::t_entry                 w_wr_entry;
    prn_pkg::t_probe                 w_probe;
    prn_pkg::t_best                  w_best;
    prn_pkg::t_reg_idx               w_reg;
    logic                            w_cfg_wr;
    logic                            w_in_acc;
    logic                            w_query;
    logic                            w_wr_en;
    logic                            w_shift;
    logic                            w_xf_done;
    logic                            w_busy;
    logic                            w_out_free;
    logic [prn_pkg::CH_W-1:0]        w_ideal_red;
    logic [prn_pkg::CH_W-1:0]        w_ideal_green;
    logic [prn_pkg::CH_W-1:0]        w_ideal_blue;
    logic [prn_pkg::CMP_W-1:0]       w_pos;
    logic [prn_pkg::CMP_W-1:0]       w_limit;
    logic [prn_pkg::CMP_W-1:0]       w_blk_end;
    logic                            w_blocked;

    // APB register file; writes complete in the access phase.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign w_reg    = prn_pkg::t_reg_idx'(paddr[prn_pkg::ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= prn_pkg::CFG_RESET;
        end else if (w_cfg_wr) begin
            unique case (w_reg)
                prn_pkg::REG_MODE:          r_cfg.mode          <= prn_pkg::t_mode'(pwdata[1:0]);
                prn_pkg::REG_PERCENT:       r_cfg.percent       <= pwdata[9:0];
                prn_pkg::REG_GRAY:          r_cfg.gray          <= pwdata[6:0];
                prn_pkg::REG_BLOCKED_START: r_cfg.blocked_start <= pwdata[7:0];
                prn_pkg::REG_BLOCKED_COUNT: r_cfg.blocked_count <= pwdata[8:0];
                prn_pkg::REG_START_COLOR:   r_cfg.start_color   <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (w_reg)
            prn_pkg::REG_MODE:          prdata = prn_pkg::DATA_W'(r_cfg.mode);
            prn_pkg::REG_PERCENT:       prdata = prn_pkg::DATA_W'(r_cfg.percent);
            prn_pkg::REG_GRAY:          prdata = prn_pkg::DATA_W'(r_cfg.gray);
            prn_pkg::REG_BLOCKED_START: prdata = prn_pkg::DATA_W'(r_cfg.blocked_start);
            prn_pkg::REG_BLOCKED_COUNT: prdata = prn_pkg::DATA_W'(r_cfg.blocked_count);
            prn_pkg::REG_START_COLOR:   prdata = prn_pkg::DATA_W'(r_cfg.start_color);
            default:                    prdata = '0;
        endcase
    end

    // Input handshake: beats are taken only between queries.
    assign i_in.ready = (r_state == ST_IDLE);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_query    = w_in_acc && (i_in.kind == prn_pkg::KIND_QUERY);
    assign w_wr_en    = w_in_acc && (i_in.kind == prn_pkg::KIND_WRITE);
    assign w_shift    = (r_state == ST_SCAN);
    assign w_wr_entry = '{cycling: i_in.entry_cycling, red: i_in.red,
                          green: i_in.green, blue: i_in.blue};

    // Palette ring: each cell hands its entry to the one below while scanning.
    for (genvar gi = 0; gi < prn_pkg::PALETTE_DEPTH; gi++) begin : g_cell
        localparam int NEXT = (gi + 1) % prn_pkg::PALETTE_DEPTH;
        prn_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_load       (w_wr_en && (i_in.entry_index == 8'(gi))),
            .i_load_entry (w_wr_entry),
            .i_shift      (w_shift),
            .i_next       (w_cell[NEXT]),
            .o_entry      (w_cell[gi])
        );
    end

    // Ideal color pipeline.
    prn_xform u_xform (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (w_query),
        .i_red         (i_in.red),
        .i_green       (i_in.green),
        .i_blue        (i_in.blue),
        .i_cfg         (r_cfg),
        .o_done        (w_xf_done),
        .o_ideal_red   (w_ideal_red),
        .o_ideal_green (w_ideal_green),
        .o_ideal_blue  (w_ideal_blue)
    );

    // Candidate test for the entry at the head of the ring.
    always_comb begin
        w_pos     = prn_pkg::CMP_W'(r_cnt);
        w_limit   = (prn_pkg::CMP_W'(r_cfg.start_color) > prn_pkg::CMP_W'(prn_pkg::PALETTE_DEPTH))
                  ? prn_pkg::CMP_W'(prn_pkg::PALETTE_DEPTH)
                  : prn_pkg::CMP_W'(r_cfg.start_color);
        w_blk_end = prn_pkg::CMP_W'(r_cfg.blocked_start) + prn_pkg::CMP_W'(r_cfg.blocked_count);
        w_blocked = (r_cfg.blocked_count != '0)
                 && (w_pos >= prn_pkg::CMP_W'(r_cfg.blocked_start))
                 && (w_pos < w_blk_end);
        w_probe   = '{valid: w_shift,
                      cand:  !w_cell[0].cycling && (w_pos < w_limit) && !w_blocked,
                      idx:   r_cnt[prn_pkg::IDX_W-1:0],
                      red:   w_cell[0].red,
                      green: w_cell[0].green,
                      blue:  w_cell[0].blue};
    end

    // Distance and best-match tracking.
    prn_dist u_dist (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_clear       (w_query),
        .i_probe       (w_probe),
        .i_ideal_red   (w_ideal_red),
        .i_ideal_green (w_ideal_green),
        .i_ideal_blue  (w_ideal_blue),
        .o_best        (w_best),
        .o_busy        (w_busy)
    );

    assign w_out_free = !r_out_valid || o_out.ready;

    // Query sequencer and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // A taken result frees the register unless a new one loads in the same cycle.
            if (r_out_valid && o_out.ready && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_query) begin
                        r_state <= ST_XFORM;
                    end
                end
                ST_XFORM: begin
                    if (w_xf_done) begin
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (r_cnt == CNT_LAST) begin
                        r_cnt   <= '0;
                        r_state <= ST_DRAIN;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    if (!w_busy) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_found <= w_best.found;
                        r_out_idx   <= w_best.found ? 8'(w_best.idx) : '0;
                        r_out_dist  <= w_best.found ? w_best.sq_dist : '0;
                        r_out_red   <= w_ideal_red;
                        r_out_green <= w_ideal_green;
                        r_out_blue  <= w_ideal_blue;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.found         = r_out_found;
    assign o_out.best_index    = r_out_idx;
    assign o_out.best_distance = r_out_dist;
    assign o_out.ideal_red     = r_out_red;
    assign o_out.ideal_green   = r_out_green;
    assign o_out.ideal_blue    = r_out_blue;

    // A query closes the input until its result is loaded.
    a_query_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_query |=> !i_in.ready)
        else $error("input accepted while a query is in flight");

    // The color pipeline only finishes while the sequencer waits for it.
    a_xform_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_xf_done |-> (r_state == ST_XFORM))
        else $error("ideal color finished outside the wait state");

    // The ring stops after exactly one full rotation.
    a_scan_one_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_SCAN) && (r_cnt == CNT_LAST)) |=> (r_state == ST_DRAIN))
        else $error("ring rotation did not end after one turn");

    // Outside a scan the ring is aligned with cell zero at index zero.
    a_ring_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_SCAN) |-> (r_cnt == '0))
        else $error("scan counter left nonzero outside a scan");

    // A miss reports a zero index and distance.
    a_miss_zeroed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.found) |-> (o_out.best_index == '0 && o_out.best_distance == '0))
        else $error("result without a match carries a nonzero index or distance");

endmodule

`default_nettype wire

[hw/rtl/prn_cell.sv]
// One cell of the palette ring: holds a single entry and its cycling flag.
// Depends on prn_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none

module prn_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_load,
    input  wire prn_pkg::t_entry i_load_entry,
    input  wire logic            i_shift,
    input  wire prn_pkg::t_entry i_next,
    output prn_pkg::t_entry      o_entry
);

    logic                      r_cycling;
    logic [prn_pkg::CH_W-1:0]  r_red;
    logic [prn_pkg::CH_W-1:0]  r_green;
    logic [prn_pkg::CH_W-1:0]  r_blue;

    // The cycling flag clears on reset so an unwritten entry is a candidate.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cycling <= 1'b0;
        end else if (i_load) begin
            r_cycling <= i_load_entry.cycling;
        end else if (i_shift) begin
            r_cycling <= i_next.cycling;
        end
    end

    // Color is loaded by a write or taken from the neighbor while the ring rotates.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_red   <= i_load_entry.red;
            r_green <= i_load_entry.green;
            r_blue  <= i_load_entry.blue;
        end else if (i_shift) begin
            r_red   <= i_next.red;
            r_green <= i_next.green;
            r_blue  <= i_next.blue;
        end
    end

    assign o_entry = '{cycling: r_cycling, red: r_red, green: r_green, blue: r_blue};

endmodule

`default_nettype wire

[hw/rtl/prn_xform.sv]
// Ideal color unit: brightness scaling and desaturation toward scaled luma.
// Five-stage pipeline on three channel lanes; depends on prn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module prn_xform (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [prn_pkg::CH_W-1:0]  i_red,
    input  wire logic [prn_pkg::CH_W-1:0]  i_green,
    input  wire logic [prn_pkg::CH_W-1:0]  i_blue,
    input  wire prn_pkg::t_cfg             i_cfg,
    output logic                           o_done,
    output logic [prn_pkg::CH_W-1:0]       o_ideal_red,
    output logic [prn_pkg::CH_W-1:0]       o_ideal_green,
    output logic [prn_pkg::CH_W-1:0]       o_ideal_blue
);

    logic [4:0]                     r_v;
    logic [prn_pkg::CH_W-1:0]       r_c      [3];
    logic [prn_pkg::PROD_W-1:0]     r_prod   [3];
    logic [prn_pkg::LSUM_W-1:0]     r_lsum;
    logic [prn_pkg::CH_W-1:0]       r_bright [3];
    logic [prn_pkg::PROD_W-1:0]     r_lx;
    logic [prn_pkg::LUMA_W-1:0]     r_luma;
    logic [prn_pkg::GPROD_W-1:0]    r_gp     [3];
    logic                           r_gneg   [3];
    logic [prn_pkg::CH_W-1:0]       r_ideal  [3];

    logic [prn_pkg::CH_W-1:0]       w_in     [3];
    logic [prn_pkg::CH_W-1:0]       w_bright [3];
    logic [prn_pkg::QUO_W-1:0]      w_lq;
    logic signed [prn_pkg::QUO_W-1:0] w_diff [3];
    logic [prn_pkg::LUMA_W-1:0]     w_mag    [3];
    logic [prn_pkg::CH_W-1:0]       w_grayed [3];
    logic [prn_pkg::CH_W-1:0]       w_ideal  [3];

    assign w_in[0] = i_red;
    assign w_in[1] = i_green;
    assign w_in[2] = i_blue;

    // Stage valids walk the item through the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[3:0], i_start};
        end
    end

    // Per-lane combinational pieces between the stage registers.
    always_comb begin
        logic [prn_pkg::QUO_W-1:0] step;
        logic [prn_pkg::QUO_W:0]   up;
        w_lq = prn_pkg::div100(prn_pkg::GPROD_W'(r_lx));
        for (int ch = 0; ch < 3; ch++) begin
            w_bright[ch] = prn_pkg::sat_byte(prn_pkg::div100(prn_pkg::GPROD_W'(r_prod[ch])));
            w_diff[ch]   = $signed({5'b0, r_c[ch]}) - $signed({1'b0, r_luma});
            w_mag[ch]    = w_diff[ch][prn_pkg::QUO_W-1] ? prn_pkg::LUMA_W'(-w_diff[ch])
                                                        : prn_pkg::LUMA_W'(w_diff[ch]);
            step = prn_pkg::div100(r_gp[ch]);
            up   = (prn_pkg::QUO_W + 1)'(r_c[ch]) + (prn_pkg::QUO_W + 1)'(step);
            if (r_gneg[ch]) begin
                // Channel below luma moves up, saturating at the ceiling.
                w_grayed[ch] = (up > (prn_pkg::QUO_W + 1)'(prn_pkg::CH_MAX))
                             ? prn_pkg::CH_MAX : up[prn_pkg::CH_W-1:0];
            end else begin
                // Channel above luma moves down, stopping at zero.
                w_grayed[ch] = (step > prn_pkg::QUO_W'(r_c[ch])) ? '0
                             : prn_pkg::CH_W'(prn_pkg::QUO_W'(r_c[ch]) - step);
            end
            case (i_cfg.mode)
                prn_pkg::MODE_PASS:   w_ideal[ch] = r_c[ch];
                prn_pkg::MODE_BRIGHT: w_ideal[ch] = r_bright[ch];
                default:              w_ideal[ch] = w_grayed[ch];
            endcase
        end
    end

    // Stage registers: products, luma, gray products, final color.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_c[ch]    <= w_in[ch];
                r_prod[ch] <= prn_pkg::PROD_W'(w_in[ch]) * prn_pkg::PROD_W'(i_cfg.percent);
            end
            r_lsum <= prn_pkg::LSUM_W'(w_in[0]) * prn_pkg::LSUM_W'(prn_pkg::LUMA_R)
                    + prn_pkg::LSUM_W'(w_in[1]) * prn_pkg::LSUM_W'(prn_pkg::LUMA_G)
                    + prn_pkg::LSUM_W'(w_in[2]) * prn_pkg::LSUM_W'(prn_pkg::LUMA_B);
        end
        if (r_v[0]) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_bright[ch] <= w_bright[ch];
            end
            r_lx <= prn_pkg::PROD_W'(r_lsum[prn_pkg::LSUM_W-1:8])
                  * prn_pkg::PROD_W'(i_cfg.percent);
        end
        if (r_v[1]) begin
            r_luma <= w_lq[prn_pkg::LUMA_W-1:0];
        end
        if (r_v[2]) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_gp[ch]   <= prn_pkg::GPROD_W'(w_mag[ch]) * prn_pkg::GPROD_W'(i_cfg.gray);
                r_gneg[ch] <= w_diff[ch][prn_pkg::QUO_W-1];
            end
        end
        if (r_v[3]) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_ideal[ch] <= w_ideal[ch];
            end
        end
    end

    assign o_done        = r_v[4];
    assign o_ideal_red   = r_ideal[0];
    assign o_ideal_green = r_ideal[1];
    assign o_ideal_blue  = r_ideal[2];

endmodule

`default_nettype wire

[hw/rtl/prn_dist.sv]
// Distance unit at the head of the palette ring: squared RGB distance and best match.
// Three stages (difference, square, sum and compare); depends on prn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module prn_dist (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_clear,
    input  wire prn_pkg::t_probe           i_probe,
    input  wire logic [prn_pkg::CH_W-1:0]  i_ideal_red,
    input  wire logic [prn_pkg::CH_W-1:0]  i_ideal_green,
    input  wire logic [prn_pkg::CH_W-1:0]  i_ideal_blue,
    output prn_pkg::t_best                 o_best,
    output logic                           o_busy
);

    logic                            r_a_valid;
    logic                            r_a_cand;
    logic [prn_pkg::IDX_W-1:0]       r_a_idx;
    logic signed [prn_pkg::CH_W:0]   r_a_d [3];
    logic                            r_b_valid;
    logic                            r_b_cand;
    logic [prn_pkg::IDX_W-1:0]       r_b_idx;
    logic [prn_pkg::SQ_W-1:0]        r_b_sq [3];
    logic                            r_found;
    logic [prn_pkg::IDX_W-1:0]       r_best_idx;
    logic [prn_pkg::DIST_W-1:0]      r_best_dist;

    logic [prn_pkg::CH_W-1:0]        w_ent [3];
    logic [prn_pkg::CH_W-1:0]        w_ref [3];
    logic signed [2*prn_pkg::CH_W+1:0] w_sq [3];
    logic [prn_pkg::DIST_W-1:0]      w_sum;
    logic                            w_take;

    assign w_ent[0] = i_probe.red;
    assign w_ent[1] = i_probe.green;
    assign w_ent[2] = i_probe.blue;
    assign w_ref[0] = i_ideal_red;
    assign w_ref[1] = i_ideal_green;
    assign w_ref[2] = i_ideal_blue;

    // Squares of the channel differences and their sum.
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            w_sq[ch] = r_a_d[ch] * r_a_d[ch];
        end
        w_sum  = prn_pkg::DIST_W'(r_b_sq[0]) + prn_pkg::DIST_W'(r_b_sq[1])
               + prn_pkg::DIST_W'(r_b_sq[2]);
        // Strictly smaller wins, so the first entry is kept on ties.
        w_take = r_b_valid && r_b_cand && (!r_found || (w_sum < r_best_dist));
    end

    // Stage valids and the found flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_found   <= 1'b0;
        end else begin
            r_a_valid <= i_probe.valid;
            r_b_valid <= r_a_valid;
            if (i_clear) begin
                r_found <= 1'b0;
            end else if (w_take) begin
                r_found <= 1'b1;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_a_cand <= i_probe.cand;
        r_a_idx  <= i_probe.idx;
        for (int ch = 0; ch < 3; ch++) begin
            r_a_d[ch]  <= $signed({1'b0, w_ent[ch]}) - $signed({1'b0, w_ref[ch]});
            r_b_sq[ch] <= w_sq[ch][prn_pkg::SQ_W-1:0];
        end
        r_b_cand <= r_a_cand;
        r_b_idx  <= r_a_idx;
        if (w_take) begin
            r_best_idx  <= r_b_idx;
            r_best_dist <= w_sum;
        end
    end

    assign o_best = '{found: r_found, idx: r_best_idx, sq_dist: r_best_dist};
    assign o_busy = r_a_valid || r_b_valid;

endmodule

`default_nettype wire
